// File: src/sliding_window_geometric_median_2d_defines.svh
// Assertion macros for the geometric median filter
`ifndef SLIDING_WINDOW_GEOMETRIC_MEDIAN_2D_DEFINES_SVH
`define SLIDING_WINDOW_GEOMETRIC_MEDIAN_2D_DEFINES_SVH
`ifndef SYNTHESIS
`define SWGM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SWGM_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SWGM_ASSERT(label, clk, rst_n, prop)
`define SWGM_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: src/swgm_pkg.sv
// Shared types and constants for the geometric median filter
`timescale 1ns / 1ps
package swgm_pkg;
    localparam int WindowMax = 32;
    localparam int IdxW = $clog2(WindowMax);
    localparam int CntW = IdxW + 1;
    localparam int IterLimit = 150;
    localparam int IterW = 8;
    localparam logic [63:0] NearSq = 64'd4295;
    localparam logic signed [47:0] StartX = -48'sd65536;
    localparam logic signed [47:0] StartY = -48'sd131072;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_CLEAR_ACC, CMD_READ, CMD_DIFF, CMD_SQ, CMD_SUM,
        CMD_SQRT_START, CMD_DIV_W_START, CMD_ACC, CMD_DIVX_START, CMD_DIVY_START,
        CMD_UPDATE, CMD_INIT_EST
    } cmd_e_t;

    typedef struct packed {
        cmd_e_t          cmd;
        logic [IdxW-1:0] slot;
    } dp_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic near;
        logic sw_zero;
        logic same;
    } dp_stat_t;
endpackage

// File: src/swgm_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module swgm_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: src/swgm_divu.sv
// Restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module swgm_divu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [95:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic [95:0] quo
);
    logic [95:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] d_reg;
    logic [6:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg[63:0], q_reg[95]} - {1'b0, d_reg};
        if (start) begin
            q_next = num;
            r_next = '0;
            n_next = 7'd96;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                r_next = trial;
                q_next = {q_reg[94:0], 1'b1};
            end else begin
                r_next = {r_reg[63:0], q_reg[95]};
                q_next = {q_reg[94:0], 1'b0};
            end
            n_next = n_reg - 7'd1;
            if (n_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quo = q_reg;
endmodule

// File: src/swgm_sqrt.sv
// Bit-serial integer square root, one result bit per cycle
`timescale 1ns / 1ps
module swgm_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] val,
    output logic        busy,
    output logic [31:0] root
);
    logic [63:0] v_reg, v_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] r_reg, r_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic [33:0] shifted, trial;

    always_comb begin
        v_next = v_reg;
        rem_next = rem_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        shifted = {rem_reg[31:0], v_reg[63:62]};
        trial = shifted - {r_reg, 2'b01};
        if (start) begin
            v_next = val;
            rem_next = '0;
            r_next = '0;
            n_next = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            v_next = {v_reg[61:0], 2'b00};
            if (!trial[33]) begin
                rem_next = trial;
                r_next = {r_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted;
                r_next = {r_reg[30:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
        v_reg <= v_next;
        rem_reg <= rem_next;
        r_reg <= r_next;
    end

    assign busy = busy_reg;
    assign root = r_reg;
endmodule

// File: src/swgm_datapath.sv
// Weiszfeld datapath: window RAM, distance, weight and estimate registers
`timescale 1ns / 1ps
module swgm_datapath
    import swgm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_cmd_t       cmd,
    input  logic          wr_en,
    input  logic [IdxW-1:0] wr_slot,
    input  logic [29:0]   wr_data,
    output dp_stat_t      stat,
    output logic [14:0]   med_x,
    output logic [14:0]   med_y,
    output logic [29:0]   rd_point
);
    logic [29:0] rd_data;
    logic [IdxW-1:0] ram_addr;
    assign ram_addr = wr_en ? wr_slot : cmd.slot;

    swgm_ram #(.Width(30), .Depth(WindowMax)) u_ram (
        .aclk(aclk), .we(wr_en), .addr(ram_addr), .wdata(wr_data), .rdata(rd_data)
    );

    logic signed [47:0] cx_reg, cy_reg, nx_reg, ny_reg;
    logic [14:0] px_reg, py_reg;
    logic [47:0] dx_reg, dy_reg;
    logic [63:0] sqx_reg, sqy_reg, s_reg;
    logic [63:0] sw_reg, swx_reg, swy_reg;

    logic sq_start, dv_start, sq_busy, dv_busy;
    logic [31:0] root;
    logic [95:0] dv_num, dv_quo;
    logic [63:0] dv_den;

    swgm_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .val(s_reg),
        .busy(sq_busy), .root(root)
    );
    swgm_divu u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(dv_num),
        .den(dv_den), .busy(dv_busy), .quo(dv_quo)
    );

    logic [47:0] pxs, pys;
    assign pxs = {21'd0, px_reg, 12'd0};
    assign pys = {21'd0, py_reg, 12'd0};

    always_comb begin
        sq_start = (cmd.cmd == CMD_SQRT_START);
        dv_start = (cmd.cmd == CMD_DIV_W_START) || (cmd.cmd == CMD_DIVX_START)
            || (cmd.cmd == CMD_DIVY_START);
        dv_num = '0;
        dv_den = sw_reg;
        unique case (cmd.cmd)
            CMD_DIV_W_START: begin
                dv_num = 96'd1 << 40;
                dv_den = {32'd0, root};
            end
            CMD_DIVX_START: dv_num = {20'd0, swx_reg, 12'd0};
            CMD_DIVY_START: dv_num = {20'd0, swy_reg, 12'd0};
            default: dv_num = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.cmd)
            CMD_INIT_EST: begin
                cx_reg <= StartX;
                cy_reg <= StartY;
            end
            CMD_CLEAR_ACC: begin
                sw_reg <= '0;
                swx_reg <= '0;
                swy_reg <= '0;
            end
            CMD_LOAD: begin
                px_reg <= rd_data[14:0];
                py_reg <= rd_data[29:15];
            end
            CMD_DIFF: begin
                dx_reg <= (cx_reg >= $signed(pxs)) ? 48'(cx_reg - $signed(pxs))
                                                   : 48'($signed(pxs) - cx_reg);
                dy_reg <= (cy_reg >= $signed(pys)) ? 48'(cy_reg - $signed(pys))
                                                   : 48'($signed(pys) - cy_reg);
            end
            CMD_SQ: begin
                // diffs fit in 32 bits for in-range estimates
                sqx_reg <= 64'(dx_reg[31:0] * dx_reg[31:0]);
                sqy_reg <= 64'(dy_reg[31:0] * dy_reg[31:0]);
            end
            CMD_SUM: s_reg <= sqx_reg + sqy_reg;
            CMD_ACC: begin
                sw_reg <= sw_reg + dv_quo[63:0];
                swx_reg <= swx_reg + 64'(dv_quo[47:0] * px_reg);
                swy_reg <= swy_reg + 64'(dv_quo[47:0] * py_reg);
            end
            CMD_DIVY_START: nx_reg <= $signed(dv_quo[47:0]);
            CMD_UPDATE: begin
                if (sw_reg == '0) begin
                    nx_reg <= cx_reg;
                    ny_reg <= cy_reg;
                end else begin
                    ny_reg <= $signed(dv_quo[47:0]);
                end
            end
            CMD_READ: begin
                cx_reg <= nx_reg;
                cy_reg <= ny_reg;
            end
            default: ;
        endcase
    end

    function automatic logic [14:0] to_q(input logic signed [47:0] e);
        logic [47:0] v;
        v = 48'(e + 48'sd2048) >> 12;
        if (e < 0) return 15'd0;
        if (v > 48'd32767) return 15'h7FFF;
        return v[14:0];
    endfunction

    assign med_x = to_q(nx_reg);
    assign med_y = to_q(ny_reg);
    assign rd_point = rd_data;
    assign stat.unit_done = !sq_busy && !dv_busy;
    assign stat.near = (s_reg < NearSq);
    assign stat.sw_zero = (sw_reg == '0);
    assign stat.same = (nx_reg == cx_reg) && (ny_reg == cy_reg);
endmodule

// File: src/swgm_ctrl.sv
// Controller for the window bookkeeping and the Weiszfeld passes
`timescale 1ns / 1ps
`include "sliding_window_geometric_median_2d_defines.svh"
module swgm_ctrl
    import swgm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          in_valid_pt,
    input  logic [29:0]   in_point,
    input  logic [5:0]    win_len,
    input  logic          out_fire,
    input  dp_stat_t      stat,
    input  logic [29:0]   rd_point,
    input  logic [14:0]   med_x,
    input  logic [14:0]   med_y,
    output dp_cmd_t       cmd,
    output logic          wr_en,
    output logic [IdxW-1:0] wr_slot,
    output logic [29:0]   wr_data,
    output logic          in_ready,
    output logic          out_valid,
    output logic [14:0]   out_x,
    output logic [14:0]   out_y,
    output logic [5:0]    out_fill,
    output logic          out_nc
);
    typedef enum logic [4:0] {
        S_IDLE, S_TRIM, S_DECIDE, S_SINGLE_RD, S_SINGLE_WAIT, S_SINGLE,
        S_PASS, S_RD, S_RD_WAIT, S_LOAD, S_DIFF, S_SQ, S_SUM, S_SQRT, S_SQRT_W,
        S_DIVW_W, S_ACC, S_DIVX, S_DIVX_W, S_DIVY, S_DIVY_W, S_UPD, S_CHECK,
        S_FINISH, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [IdxW-1:0] oldest_reg, oldest_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic [IdxW-1:0] k_reg, k_next;
    logic [IterW-1:0] pass_reg, pass_next;
    logic out_valid_reg, out_valid_next;
    logic [14:0] ox_reg, ox_next, oy_reg, oy_next;
    logic nc_reg, nc_next;
    logic [CntW-1:0] len;

    assign len = (win_len > 6'(WindowMax)) ? CntW'(WindowMax) : CntW'(win_len);

    always_comb begin
        state_next = state_reg;
        oldest_next = oldest_reg;
        fill_next = fill_reg;
        k_next = k_reg;
        pass_next = pass_reg;
        out_valid_next = out_valid_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        nc_next = nc_reg;
        cmd.cmd = CMD_NONE;
        cmd.slot = IdxW'(oldest_reg + k_reg);
        wr_en = 1'b0;
        wr_slot = IdxW'(oldest_reg + fill_reg[IdxW-1:0]);
        wr_data = in_point;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_valid_pt) begin
                        wr_en = 1'b1;
                        if (fill_reg >= CntW'(WindowMax)) begin
                            wr_slot = oldest_reg;
                            oldest_next = IdxW'(oldest_reg + 1'b1);
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    state_next = S_TRIM;
                end
            end
            S_TRIM: begin
                if (fill_reg > len) begin
                    oldest_next = IdxW'(oldest_reg + 1'b1);
                    fill_next = fill_reg - 1'b1;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                nc_next = 1'b0;
                k_next = '0;
                pass_next = '0;
                cmd.cmd = CMD_INIT_EST;
                if (fill_reg == '0) begin
                    ox_next = '0;
                    oy_next = '0;
                    state_next = S_OUT;
                    out_valid_next = 1'b1;
                end else if (fill_reg == CntW'(1)) begin
                    state_next = S_SINGLE_WAIT;
                end else begin
                    state_next = S_PASS;
                end
            end
            S_SINGLE_RD: state_next = S_SINGLE_WAIT;
            S_SINGLE_WAIT: state_next = S_SINGLE;
            S_SINGLE: begin
                ox_next = rd_point[14:0];
                oy_next = rd_point[29:15];
                out_valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_PASS: begin
                cmd.cmd = CMD_CLEAR_ACC;
                k_next = '0;
                state_next = S_RD;
            end
            S_RD: state_next = S_RD_WAIT;
            S_RD_WAIT: state_next = S_LOAD;
            S_LOAD: begin
                cmd.cmd = CMD_LOAD;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.cmd = CMD_DIFF;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.cmd = CMD_SQ;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.cmd = CMD_SUM;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                if (stat.near) begin
                    state_next = S_CHECK;
                end else begin
                    cmd.cmd = CMD_SQRT_START;
                    state_next = S_SQRT_W;
                end
            end
            S_SQRT_W: begin
                if (stat.unit_done) begin
                    cmd.cmd = CMD_DIV_W_START;
                    state_next = S_DIVW_W;
                end
            end
            S_DIVW_W: begin
                if (stat.unit_done) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.cmd = CMD_ACC;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (CntW'(k_reg) + 1'b1 >= fill_reg) begin
                    state_next = S_DIVX;
                end else begin
                    k_next = IdxW'(k_reg + 1'b1);
                    state_next = S_RD;
                end
            end
            S_DIVX: begin
                if (stat.sw_zero) begin
                    state_next = S_UPD;
                end else begin
                    cmd.cmd = CMD_DIVX_START;
                    state_next = S_DIVX_W;
                end
            end
            S_DIVX_W: begin
                if (stat.unit_done) begin
                    cmd.cmd = CMD_DIVY_START;
                    state_next = S_DIVY_W;
                end
            end
            S_DIVY_W: begin
                if (stat.unit_done) begin
                    state_next = S_UPD;
                end
            end
            S_DIVY: state_next = S_UPD;
            S_UPD: begin
                cmd.cmd = CMD_UPDATE;
                pass_next = pass_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (pass_reg > IterW'(IterLimit)) begin
                    nc_next = 1'b1;
                    ox_next = med_x;
                    oy_next = med_y;
                    out_valid_next = 1'b1;
                    state_next = S_OUT;
                end else if (stat.same) begin
                    ox_next = med_x;
                    oy_next = med_y;
                    out_valid_next = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.cmd = CMD_READ;
                    state_next = S_PASS;
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    out_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            oldest_reg <= '0;
            fill_reg <= '0;
            k_reg <= '0;
            pass_reg <= '0;
            out_valid_reg <= 1'b0;
            nc_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            oldest_reg <= oldest_next;
            fill_reg <= fill_next;
            k_reg <= k_next;
            pass_reg <= pass_next;
            out_valid_reg <= out_valid_next;
            nc_reg <= nc_next;
        end
        ox_reg <= ox_next;
        oy_reg <= oy_next;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_fill = 6'(fill_reg);
    assign out_nc = nc_reg;

    `SWGM_ASSERT(a_fill_max, aclk, aresetn, fill_reg <= CntW'(WindowMax))
    `SWGM_ASSERT(a_valid_out, aclk, aresetn, out_valid_reg |-> state_reg == S_OUT)
    `SWGM_ASSERT(a_pass_lim, aclk, aresetn, pass_reg <= IterW'(IterLimit + 1))
    `SWGM_ASSERT(a_nc_fill, aclk, aresetn, (out_valid_reg && nc_reg) |-> fill_reg >= CntW'(2))
endmodule

// File: src/sliding_window_geometric_median_2d.sv
// Top level of the sliding-window 2D geometric median filter
`timescale 1ns / 1ps
// Each accepted point (negative coordinates are dropped) enters a window of
// the last window_length points; one result follows per input transaction.
// Two or more points run Weiszfeld passes, each visiting every held point
// with a square root and a division (skipped for a point near the estimate),
// plus two divisions per pass when the weight sum is nonzero; up to 151 passes.
// A new input is taken only after the previous result has been accepted.
module sliding_window_geometric_median_2d
    import swgm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // sample_x[15:0], sample_y[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // median_x, median_y, window_fill, not_converged
);
    logic [5:0] win_len_reg;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic wr_en, in_fire, out_fire;
    logic [IdxW-1:0] wr_slot;
    logic [29:0] wr_data, rd_point;
    logic [14:0] med_x, med_y, ox, oy;
    logic [5:0] fill;
    logic nc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= 6'd8;
        end else if (cfg_wr_en) begin
            win_len_reg <= cfg_wr_data;
        end
    end

    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    swgm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_valid_pt(!s_tdata[15] && !s_tdata[31]),
        .in_point({s_tdata[30:16], s_tdata[14:0]}), .win_len(win_len_reg),
        .out_fire(out_fire), .stat(stat), .rd_point(rd_point), .med_x(med_x),
        .med_y(med_y), .cmd(cmd), .wr_en(wr_en), .wr_slot(wr_slot),
        .wr_data(wr_data), .in_ready(s_tready), .out_valid(m_tvalid),
        .out_x(ox), .out_y(oy), .out_fill(fill), .out_nc(nc)
    );

    swgm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .wr_en(wr_en),
        .wr_slot(wr_slot), .wr_data(wr_data), .stat(stat), .med_x(med_x),
        .med_y(med_y), .rd_point(rd_point)
    );

    assign m_tdata = {3'd0, nc, fill, oy, ox};
endmodule

// File: tb/swgm_checker.sv
// Checker for the geometric median filter: predicts each result and compares it
`timescale 1ns / 1ps
module swgm_checker
    import swgm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatch_count,
    output int          medians_pending
);
    typedef struct packed {
        logic        not_converged;
        logic [5:0]  window_fill;
        logic [14:0] median_y;
        logic [14:0] median_x;
    } median_t;

    logic [29:0]     points [WindowMax];
    logic [IdxW-1:0] head;
    logic [CntW-1:0] held;
    logic [5:0]      win_len;
    median_t         median_q [$];
    int              errs;

    assign mismatch_count  = errs;
    assign medians_pending = median_q.size();

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] scaled_div(input logic [63:0] num, input logic [63:0] den);
        return ((num / den) << 12) + (((num % den) << 12) / den);
    endfunction

    function automatic logic [14:0] est_to_q11_4(input longint est);
        logic [63:0] v;
        if (est < 0) return 15'd0;
        v = (64'(est) + 64'd2048) >> 12;
        return (v > 64'd32767) ? 15'h7fff : v[14:0];
    endfunction

    // Weiszfeld passes over the held points; returns 1 when the pass limit ends it
    function automatic logic run_weiszfeld(output longint ex, output longint ey);
        longint      cx, cy, nx, ny, px, py, a, b;
        logic [63:0] sw, swx, swy, dx, dy, s, w;
        int          passes;
        logic [29:0] e;
        cx = -65536;
        cy = -131072;
        passes = 0;
        forever begin
            sw = 0; swx = 0; swy = 0;
            for (int k = 0; k < held; k++) begin
                e  = points[IdxW'(head + k)];
                px = longint'(e[14:0]);
                py = longint'(e[29:15]);
                a  = px <<< 12;
                b  = py <<< 12;
                dx = (cx >= a) ? 64'(cx - a) : 64'(a - cx);
                dy = (cy >= b) ? 64'(cy - b) : 64'(b - cy);
                s  = dx * dx + dy * dy;
                if (s >= NearSq) begin
                    w   = (64'd1 << 40) / isqrt64(s);
                    sw  = sw + w;
                    swx = swx + w * 64'(px);
                    swy = swy + w * 64'(py);
                end
            end
            if (sw == 0) begin
                nx = cx;
                ny = cy;
            end else begin
                nx = longint'(scaled_div(swx, sw));
                ny = longint'(scaled_div(swy, sw));
            end
            passes++;
            ex = nx;
            ey = ny;
            if (passes > IterLimit) return 1'b1;
            if (nx == cx && ny == cy) return 1'b0;
            cx = nx;
            cy = ny;
        end
    endfunction

    function automatic median_t predict_median(input logic [15:0] sx, input logic [15:0] sy);
        median_t     r;
        int          lim;
        longint      ex, ey;
        logic [29:0] e;
        lim = (win_len > WindowMax) ? WindowMax : win_len;
        if (!sx[15] && !sy[15]) begin
            if (held >= WindowMax) begin
                head = head + 1'b1;
                held = held - 1'b1;
            end
            points[IdxW'(head + held)] = {sy[14:0], sx[14:0]};
            held = held + 1'b1;
        end
        while (held > lim) begin
            head = head + 1'b1;
            held = held - 1'b1;
        end
        r = '0;
        r.window_fill = 6'(held);
        if (held == 1) begin
            e = points[head];
            r.median_x = e[14:0];
            r.median_y = e[29:15];
        end else if (held >= 2) begin
            r.not_converged = run_weiszfeld(ex, ey);
            r.median_x = est_to_q11_4(ex);
            r.median_y = est_to_q11_4(ey);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        median_t want, got;
        if (!aresetn) begin
            head    = '0;
            held    = '0;
            win_len = 6'd8;
            median_q.delete();
            errs    = 0;
        end else begin
            if (cfg_wr_en) win_len = cfg_wr_data;
            if (s_tvalid && s_tready)
                median_q.insert(median_q.size(),
                                predict_median(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[36:0];
                if (median_q.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, got);
                    errs++;
                end else begin
                    want = median_q[0];
                    median_q.delete(0);
                    if (got.median_x !== want.median_x || got.median_y !== want.median_y ||
                        got.window_fill !== want.window_fill ||
                        got.not_converged !== want.not_converged || m_tdata[39:37] !== 3'b0) begin
                        $display("%0t: expected x=%0d y=%0d fill=%0d nc=%0b, actual x=%0d y=%0d fill=%0d nc=%0b",
                                 $time, want.median_x, want.median_y, want.window_fill,
                                 want.not_converged, got.median_x, got.median_y,
                                 got.window_fill, got.not_converged);
                        errs++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sliding_window_geometric_median_2d_tb.sv
// Stimulus and verdict for the sliding-window geometric median filter
`timescale 1ns / 1ps
module sliding_window_geometric_median_2d_tb;
    import swgm_pkg::*;

    localparam longint CycleLimit = 1_000_000_000;
    localparam int     HoldCycles = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          mismatch_count;
    int          medians_pending;

    int     send_idle = 0;
    int     recv_idle = 0;
    int     hold_reqs = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    longint cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sliding_window_geometric_median_2d dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    swgm_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatch_count(mismatch_count), .medians_pending(medians_pending)
    );

    // result side: random stalls plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_point(input logic [15:0] x, input logic [15:0] y);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_medians();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (medians_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_window(input logic [5:0] len);
        drain_medians();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly points near a common center, sometimes any 16-bit pattern
    task automatic send_random(input int n, input int spread);
        logic [15:0] cx, cy;
        cx = 16'($urandom_range(32767 - spread));
        cy = 16'($urandom_range(32767 - spread));
        repeat (n) begin
            if ($urandom_range(9) < 8)
                send_point(cx + 16'($urandom_range(spread)), cy + 16'($urandom_range(spread)));
            else
                send_point(16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, invalid samples, coincident points, single point
        send_point(16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd0);
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'd100);
        send_point(16'd100, 16'hffff);
        send_point(16'h8000, 16'h8000);
        send_point(16'd0, 16'h7fff);
        send_point(16'h7fff, 16'd0);
        send_point(16'd1, 16'd1);
        send_point(16'h5555, 16'h2aaa);
        send_point(16'h2aaa, 16'h5555);
        set_window(6'd1);
        send_point(16'd1234, 16'd4321);
        send_point(16'hffff, 16'd5);
        set_window(6'd0);
        send_point(16'd77, 16'd88);
        send_point(16'h8001, 16'd0);
        set_window(6'd2);
        send_point(16'd500, 16'd500);
        send_point(16'd500, 16'd500);
        send_point(16'd500, 16'd501);
        send_point(16'd0, 16'h7fff);

        send_idle = 19;
        recv_idle = 81;
        set_window(6'd3);
        send_random(15, 255);
        hold_reqs++;
        send_random(10, 63);
        send_idle = 81;
        recv_idle = 19;
        set_window(6'd4);
        send_random(15, 1023);
        drain_medians();
        send_random(10, 15);
        set_window(6'd1);
        send_random(6, 4095);

        send_idle = 0;
        recv_idle = 0;
        set_window(6'd32);
        send_random(36, 7);
        set_window(6'd3);
        send_random(4, 31);
        set_window(6'd63);
        send_random(3, 31);

        drain_medians();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: sliding_window_geometric_median_2d.f
+incdir+src
src/swgm_pkg.sv
src/swgm_ram.sv
src/swgm_divu.sv
src/swgm_sqrt.sv
src/swgm_datapath.sv
src/swgm_ctrl.sv
src/sliding_window_geometric_median_2d.sv
tb/swgm_checker.sv
tb/sliding_window_geometric_median_2d_tb.sv
